// ----- sv/lapm_pkg.sv -----
// Shared constants, codes and types of the leading-one approximate multiplier.
package lapm_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int FRAC_BITS     = OPERAND_WIDTH - 1;
	localparam int POS_BITS      = $clog2(OPERAND_WIDTH);
	localparam int EXP_BITS      = POS_BITS + 1;
	localparam int SUM_BITS      = FRAC_BITS + 2;
	localparam int PROD_BITS     = 2 * OPERAND_WIDTH;
	localparam int CORR_BITS     = 13;

	// Correction rule codes held in the variant register.
	localparam logic [1:0] VAR_TWO   = 2'd0;
	localparam logic [1:0] VAR_THREE = 2'd1;
	localparam logic [1:0] VAR_FIVE  = 2'd2;
	localparam logic [1:0] VAR_RESET = VAR_FIVE;

	// Region bounds on the 15-bit fractions.
	localparam logic [FRAC_BITS-1:0] B_2048  = 15'd2048;
	localparam logic [FRAC_BITS-1:0] B_4096  = 15'd4096;
	localparam logic [FRAC_BITS-1:0] B_6144  = 15'd6144;
	localparam logic [FRAC_BITS-1:0] B_12288 = 15'd12288;
	localparam logic [FRAC_BITS-1:0] B_14336 = 15'd14336;
	localparam logic [FRAC_BITS-1:0] B_18432 = 15'd18432;
	localparam logic [FRAC_BITS-1:0] B_20480 = 15'd20480;
	localparam logic [FRAC_BITS-1:0] B_26624 = 15'd26624;
	localparam logic [FRAC_BITS-1:0] B_28672 = 15'd28672;
	localparam logic [FRAC_BITS-1:0] B_30720 = 15'd30720;

	// Correction terms.
	localparam logic [CORR_BITS-1:0] C_NONE = 13'd0;
	localparam logic [CORR_BITS-1:0] C_128  = 13'd128;
	localparam logic [CORR_BITS-1:0] C_504  = 13'd504;
	localparam logic [CORR_BITS-1:0] C_896  = 13'd896;
	localparam logic [CORR_BITS-1:0] C_1024 = 13'd1024;
	localparam logic [CORR_BITS-1:0] C_1536 = 13'd1536;
	localparam logic [CORR_BITS-1:0] C_2048 = 13'd2048;
	localparam logic [CORR_BITS-1:0] C_3072 = 13'd3072;
	localparam logic [CORR_BITS-1:0] C_3584 = 13'd3584;
	localparam logic [CORR_BITS-1:0] C_4096 = 13'd4096;

	// One operand split into its leading-one position and aligned fraction.
	typedef struct packed {
		logic [POS_BITS-1:0]  pos;
		logic [FRAC_BITS-1:0] frac;
	} norm_t;

endpackage

// ----- sv/lapm_norm.sv -----
// Leading-one detector and fraction alignment for one operand.
module lapm_norm import lapm_pkg::*; (
	input  logic [OPERAND_WIDTH-1:0] operand,
	output norm_t                    norm
);

	logic [POS_BITS-1:0]      pos;
	logic [OPERAND_WIDTH-1:0] aligned;

	always_comb begin
		pos = '0;
		for (int i = 0; i < OPERAND_WIDTH; i++) begin
			if (operand[i]) begin
				pos = POS_BITS'(i);
			end
		end
	end

	// Shifting the leading one up to the top bit leaves the fraction below it.
	assign aligned   = operand << (POS_BITS'(FRAC_BITS) - pos);
	assign norm.pos  = pos;
	assign norm.frac = aligned[FRAC_BITS-1:0];

endmodule

// ----- sv/lapm_corr.sv -----
// Region-based correction term for the selected correction rule.
module lapm_corr import lapm_pkg::*; (
	input  logic [1:0]           variant,
	input  logic [FRAC_BITS-1:0] fa,
	input  logic [FRAC_BITS-1:0] fb,
	output logic [CORR_BITS-1:0] corr
);

	logic [CORR_BITS-1:0] corr_two;
	logic [CORR_BITS-1:0] corr_three;
	logic [CORR_BITS-1:0] corr_five;

	always_comb begin
		if (fa >= B_6144 && fa <= B_26624 && fb >= B_6144 && fb <= B_26624) begin
			corr_two = C_3072;
		end else begin
			corr_two = C_896;
		end
	end

	always_comb begin
		if ((fa >= B_6144 && fa <= B_18432 && fb >= B_14336 && fb <= B_26624) ||
		    (fb >= B_6144 && fb <= B_18432 && fa >= B_14336 && fa <= B_26624)) begin
			corr_three = C_3584;
		end else if (fa < B_4096 || fb < B_4096 || fa > B_28672 || fb > B_28672) begin
			corr_three = C_504;
		end else begin
			corr_three = C_1536;
		end
	end

	// The five-region tests are ordered; the first one that matches wins.
	always_comb begin
		if (fa <= B_2048 || fa >= B_30720 || fb <= B_2048 || fb >= B_30720) begin
			corr_five = C_128;
		end else if ((fa < B_12288 && fb < B_12288) ||
		             (fa >= B_20480 && fb >= B_20480)) begin
			corr_five = C_1024;
		end else if (fa >= B_12288 && fa < B_20480 && fb >= B_12288 && fb < B_20480) begin
			corr_five = C_4096;
		end else if (fa >= B_6144 && fa < B_26624 && fb >= B_6144 && fb < B_26624) begin
			corr_five = C_3072;
		end else begin
			corr_five = C_2048;
		end
	end

	always_comb begin
		case (variant)
			VAR_TWO:   corr = corr_two;
			VAR_THREE: corr = corr_three;
			VAR_FIVE:  corr = corr_five;
			default:   corr = C_NONE;
		endcase
	end

endmodule

// ----- sv/lapm_core.sv -----
// Fraction sum, exponent and final shift that form the approximate product.
module lapm_core import lapm_pkg::*; (
	input  logic [1:0]               variant,
	input  logic [OPERAND_WIDTH-1:0] operand_a,
	input  logic [OPERAND_WIDTH-1:0] operand_b,
	output logic [PROD_BITS-1:0]     product
);

	norm_t                norm_a;
	norm_t                norm_b;
	logic [CORR_BITS-1:0] corr;
	logic [SUM_BITS-1:0]  sum;
	logic [EXP_BITS-1:0]  expo;
	logic [FRAC_BITS:0]   mant;
	logic [PROD_BITS-1:0] mant_wide;

	lapm_norm u_norm_a (
		.operand (operand_a),
		.norm    (norm_a)
	);

	lapm_norm u_norm_b (
		.operand (operand_b),
		.norm    (norm_b)
	);

	lapm_corr u_corr (
		.variant (variant),
		.fa      (norm_a.frac),
		.fb      (norm_b.frac),
		.corr    (corr)
	);

	// The sum stays below 2^17; its top bit, which can be set, is dropped.
	assign sum = SUM_BITS'(norm_a.frac) + SUM_BITS'(norm_b.frac) + SUM_BITS'(corr);
	assign expo = EXP_BITS'(norm_a.pos) + EXP_BITS'(norm_b.pos)
	            + EXP_BITS'(sum[FRAC_BITS]);
	assign mant = {1'b1, sum[FRAC_BITS-1:0]};
	assign mant_wide = PROD_BITS'(mant);

	always_comb begin
		if (operand_a == '0 || operand_b == '0) begin
			product = '0;
		end else if (expo >= EXP_BITS'(FRAC_BITS)) begin
			product = mant_wide << (expo - EXP_BITS'(FRAC_BITS));
		end else begin
			product = mant_wide >> (EXP_BITS'(FRAC_BITS) - expo);
		end
	end

endmodule

// ----- sv/leading_one_approx_multiplier_unit.sv -----
// Top level of the leading-one approximate multiplier: registers and ports.
//
//  Port group   Direction  Signals                          Meaning
//  command      in         start, operand_a, operand_b      operand word, taken on start & !busy
//  status       out        busy                             never high; a word is taken every cycle
//  result       out        done, product                    product word, flagged by done for one cycle
//  config       in/out     cfg_valid, cfg_ready, cfg_data   correction rule, written on valid & ready
//
// An operand word is registered at the edge that accepts it, and its product is
// registered at the next edge, together with done. One word enters each cycle;
// the path from the operand register through leading-one detection, the
// fraction add and the final shifter sets the clock period.
// Reset clears the pipeline valid flags and loads the five-region rule.
// The receiver has no way to stall, so nothing in the block ever waits.
module leading_one_approx_multiplier_unit import lapm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OPERAND_WIDTH-1:0] operand_a,
	input  logic [OPERAND_WIDTH-1:0] operand_b,
	output logic                     done,
	output logic [PROD_BITS-1:0]     product,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_data
);

	logic [1:0]               variant_q;
	logic                     valid_s1;
	logic [OPERAND_WIDTH-1:0] a_s1;
	logic [OPERAND_WIDTH-1:0] b_s1;
	logic                     valid_s2;
	logic [PROD_BITS-1:0]     product_s2;
	logic [PROD_BITS-1:0]     product_comb;
	logic                     accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			variant_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
		if (valid_s1) begin
			product_s2 <= product_comb;
		end
	end

	lapm_core u_core (
		.variant   (variant_q),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.product   (product_comb)
	);

	assign done    = valid_s2;
	assign product = product_s2;

	// Every accepted word raises done once its product has been registered.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("product word missing two cycles after start");

	// No product word appears without a matching start.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("product word without a start");

	// A zero operand always gives a zero product.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operand_a == '0 || operand_b == '0)) |=> ##1 (product == '0))
		else $error("zero operand gave a nonzero product");

endmodule
